>>> hdl/dhpm_pkg.sv
// dhpm_pkg: shared constants, codes and types of the detector hit pixel merger
// used by dhpm_div and the top level; depends on nothing
package dhpm_pkg;

   localparam int TABLE_DEPTH = 16;
   localparam int TBL_AW      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

   localparam int DIV_NW = 48;
   localparam int DIV_DW = 34;
   localparam int DIV_CW = $clog2(DIV_NW);

   localparam logic [19:0] FINE_SCALE = 20'd1000000;

   localparam logic [1:0] KIND_PIXEL   = 2'd0;
   localparam logic [1:0] KIND_SHIELD  = 2'd1;
   localparam logic [1:0] KIND_BLOCKED = 2'd2;

   localparam logic [1:0] REG_HALF_X = 2'd0;
   localparam logic [1:0] REG_HALF_Y = 2'd1;
   localparam logic [1:0] REG_PIX_X  = 2'd2;
   localparam logic [1:0] REG_PIX_Y  = 2'd3;

   typedef struct packed {
      logic [23:0] first_energy;
      logic [12:0] depth;
      logic [31:0] energy;
      logic [1:0]  tel;
      logic [2:0]  det;
      logic [27:0] xi;
      logic [27:0] yi;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   function automatic logic [15:0] half_eff(input logic [15:0] h);
      half_eff = (h == 16'd0) ? 16'd1 : h;
   endfunction

   function automatic logic [8:0] pix_eff(input logic [8:0] p);
      if (p == 9'd0) begin
         pix_eff = 9'd1;
      end else if (p > 9'd256) begin
         pix_eff = 9'd256;
      end else begin
         pix_eff = p;
      end
   endfunction

endpackage

>>> hdl/dhpm_ram.sv
// dhpm_ram: generic single write port, single read port ram with registered read
// depends on nothing
module dhpm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                         clock,
   input  logic                                         wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                             wr_data,
   input  logic                                         rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                             rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/dhpm_div.sv
// dhpm_div: restoring unsigned divider, one quotient bit per cycle
// depends on dhpm_pkg
module dhpm_div
   import dhpm_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DIV_NW-1:0] dividend,
   input  logic [DIV_DW-1:0] divisor,
   output logic              done,
   output logic [DIV_NW-1:0] quotient
);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [DIV_CW-1:0] cnt_ff, cnt_in;
   logic [DIV_NW-1:0] quo_ff, quo_in;
   logic [DIV_DW-1:0] rem_ff, rem_in;
   logic [DIV_DW-1:0] den_ff, den_in;
   logic [DIV_DW:0]   trial;
   logic [DIV_DW:0]   diff;

   assign trial = {rem_ff, quo_ff[DIV_NW-1]};
   assign diff  = trial - {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = dividend;
         rem_in  = '0;
         den_in  = divisor;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = diff[DIV_DW-1:0];
            quo_in = {quo_ff[DIV_NW-2:0], 1'b1};
         end else begin
            rem_in = trial[DIV_DW-1:0];
            quo_in = {quo_ff[DIV_NW-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CW'(DIV_NW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

>>> hdl/detector_hit_pixel_merger_unit.sv
// detector_hit_pixel_merger_unit: top level, control sequencer and hit table
// depends on dhpm_pkg, dhpm_ram and dhpm_div
//
// req channel takes interaction items and end-of-event flush items.
// a detector interaction computes a fine pixel index per axis (one division
// per axis on the shared divider unless the offset is negative), searches
// the hit table in ram one stored entry at a time, then appends, merges or,
// with a full table, sets overflow; a merge adds one more division for the
// weighted mean depth.
// a shield interaction gives one rsp item.
// a flush gives one rsp item per stored entry, tlast on the final one, or
// one blocked item for an event without any hit or shield interaction.
// items are taken one at a time; req_tready is high only while no item is
// in work. rsp has an output register, so the next req item is taken while
// a result still waits; when the receiver stalls the sequencer holds before
// loading the next result. csr writes are always taken and must only happen
// while the block is idle.
// reset empties the table, clears the event flags and sets the registers
// to 10000, 10000, 32 and 32; no clearing pass is needed.
module detector_hit_pixel_merger_unit
   import dhpm_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   // csr
   input  logic          csr_valid,
   output logic          csr_ready,
   input  logic [1:0]    csr_index,
   input  logic [15:0]   csr_data,
   // req
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [79:0]   req_tdata,  // telescope_id, detector_id, x_pos, y_pos, z_pos, energy
   input  logic [1:0]    req_tuser,  // action, in_detector
   // rsp
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [135:0]  rsp_tdata,  // hit_telescope, hit_detector, x_index, y_index,
                                     // energy_sum, mean_depth, first_energy
   output logic [2:0]    rsp_tuser,  // kind, overflow
   output logic          rsp_tlast
);

   typedef enum logic [15:0] {
      ST_IDLE    = 16'h0001,
      ST_IX_MUL1 = 16'h0002,
      ST_IX_MUL2 = 16'h0004,
      ST_IX_DIV  = 16'h0008,
      ST_SEARCH  = 16'h0010,
      ST_CHECK   = 16'h0020,
      ST_MG_SUM  = 16'h0040,
      ST_MG_MUL  = 16'h0080,
      ST_MG_NUM  = 16'h0100,
      ST_MG_N2   = 16'h0200,
      ST_MG_DST  = 16'h0400,
      ST_MG_DIV  = 16'h0800,
      ST_FL_READ = 16'h1000,
      ST_FL_LOAD = 16'h2000,
      ST_EM_BLK  = 16'h4000,
      ST_EM_SHD  = 16'h8000
   } state_type;

   state_type state_ff, state_in;

   logic [15:0] half_x_ff, half_x_in, half_y_ff, half_y_in;
   logic [8:0]  pix_x_ff, pix_x_in, pix_y_ff, pix_y_in;

   logic [CNT_W-1:0] count_ff, count_in, ptr_ff, ptr_in;
   logic             shield_ff, shield_in, ovf_ff, ovf_in;
   logic             axis_ff, axis_in;

   logic [1:0]         tel_ff, tel_in;
   logic [2:0]         det_ff, det_in;
   logic signed [16:0] x_ff, x_in, y_ff, y_in;
   logic signed [12:0] z_ff, z_in;
   logic [23:0]        e_ff, e_in;
   logic [27:0]        xi_ff, xi_in, yi_ff, yi_in;
   logic [25:0]        prod1_ff, prod1_in;
   logic [27:0]        top_ff, top_in;
   entry_type          ent_ff, ent_in;
   logic [32:0]        sum_ff, sum_in;
   logic signed [45:0] prod_a_ff, prod_a_in;
   logic signed [37:0] prod_b_ff, prod_b_in;
   logic signed [46:0] num_ff, num_in;
   logic signed [47:0] n2_ff, n2_in;
   logic               neg_ff, neg_in;

   logic         out_valid_ff, out_valid_in;
   logic [1:0]   out_kind_ff, out_kind_in;
   logic         out_last_ff, out_last_in;
   logic         out_ovf_ff, out_ovf_in;
   entry_type    out_ent_ff, out_ent_in;

   logic         out_free;
   logic         req_take;

   logic               ram_we, ram_re;
   logic [TBL_AW-1:0]  ram_waddr, ram_raddr;
   logic [ENTRY_W-1:0] ram_wdata, ram_rdata;
   entry_type          rd_ent, wr_ent;

   logic              div_start, div_done;
   logic [DIV_NW-1:0] div_num, div_q;
   logic [DIV_DW-1:0] div_den;

   logic signed [16:0] pos_sel;
   logic [15:0]        half_sel;
   logic [8:0]         pix_sel;
   logic signed [17:0] off;
   logic [27:0]        idx;
   logic [45:0]        fine_prod;
   logic               key_hit;
   logic signed [48:0] n2_full;
   logic [33:0]        d2;
   logic [12:0]        q_lo;

   dhpm_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_DEPTH)) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   dhpm_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_num),
      .divisor  (div_den),
      .done     (div_done),
      .quotient (div_q)
   );

   assign csr_ready  = 1'b1;
   assign out_free   = !out_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign req_take   = req_tvalid && req_tready;

   assign rd_ent    = entry_type'(ram_rdata);
   assign ram_wdata = ENTRY_W'(wr_ent);

   assign pos_sel   = axis_ff ? y_ff : x_ff;
   assign half_sel  = half_eff(axis_ff ? half_y_ff : half_x_ff);
   assign pix_sel   = pix_eff(axis_ff ? pix_y_ff : pix_x_ff);
   assign off       = $signed({pos_sel[16], pos_sel}) + $signed({2'b00, half_sel});
   assign idx       = (div_q > {20'd0, top_ff}) ? top_ff : div_q[27:0];
   assign fine_prod = prod1_ff * FINE_SCALE;
   assign key_hit   = (rd_ent.tel == tel_ff) && (rd_ent.det == det_ff) &&
                      (rd_ent.xi == xi_ff) && (rd_ent.yi == yi_ff);
   assign n2_full   = $signed({num_ff[46], num_ff, 1'b0}) + $signed({16'd0, sum_ff});
   assign d2        = {sum_ff, 1'b0};
   assign q_lo      = div_q[12:0];

   always_comb begin
      state_in  = state_ff;
      half_x_in = half_x_ff;
      half_y_in = half_y_ff;
      pix_x_in  = pix_x_ff;
      pix_y_in  = pix_y_ff;
      count_in  = count_ff;
      ptr_in    = ptr_ff;
      shield_in = shield_ff;
      ovf_in    = ovf_ff;
      axis_in   = axis_ff;
      tel_in    = tel_ff;
      det_in    = det_ff;
      x_in      = x_ff;
      y_in      = y_ff;
      z_in      = z_ff;
      e_in      = e_ff;
      xi_in     = xi_ff;
      yi_in     = yi_ff;
      prod1_in  = prod1_ff;
      top_in    = top_ff;
      ent_in    = ent_ff;
      sum_in    = sum_ff;
      prod_a_in = prod_a_ff;
      prod_b_in = prod_b_ff;
      num_in    = num_ff;
      n2_in     = n2_ff;
      neg_in    = neg_ff;

      out_valid_in = out_valid_ff && !rsp_tready;
      out_kind_in  = out_kind_ff;
      out_last_in  = out_last_ff;
      out_ovf_in   = out_ovf_ff;
      out_ent_in   = out_ent_ff;

      ram_we    = 1'b0;
      ram_waddr = ptr_ff[TBL_AW-1:0];
      wr_ent    = ent_ff;
      ram_re    = 1'b0;
      ram_raddr = ptr_ff[TBL_AW-1:0];
      div_start = 1'b0;
      div_num   = {2'd0, fine_prod};
      div_den   = {17'd0, half_sel, 1'b0};

      if (csr_valid) begin
         case (csr_index)
            REG_HALF_X: half_x_in = csr_data;
            REG_HALF_Y: half_y_in = csr_data;
            REG_PIX_X:  pix_x_in  = csr_data[8:0];
            REG_PIX_Y:  pix_y_in  = csr_data[8:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               tel_in  = req_tdata[1:0];
               det_in  = req_tdata[4:2];
               x_in    = req_tdata[21:5];
               y_in    = req_tdata[38:22];
               z_in    = req_tdata[51:39];
               e_in    = req_tdata[75:52];
               axis_in = 1'b0;
               ptr_in  = '0;
               if (req_tuser[0]) begin
                  if (count_ff != '0) begin
                     state_in = ST_FL_READ;
                  end else if (!shield_ff) begin
                     state_in = ST_EM_BLK;
                  end else begin
                     shield_in = 1'b0;
                     ovf_in    = 1'b0;
                  end
               end else if (!req_tuser[1]) begin
                  shield_in = 1'b1;
                  state_in  = ST_EM_SHD;
               end else begin
                  state_in = ST_IX_MUL1;
               end
            end
         end
         ST_IX_MUL1: begin
            top_in   = 28'(pix_sel * FINE_SCALE) - 28'd1;
            prod1_in = off[16:0] * pix_sel;
            if (off[17]) begin
               ovf_in = 1'b1;
               if (axis_ff) begin
                  yi_in    = '0;
                  state_in = ST_SEARCH;
               end else begin
                  xi_in   = '0;
                  axis_in = 1'b1;
               end
            end else begin
               state_in = ST_IX_MUL2;
            end
         end
         ST_IX_MUL2: begin
            div_start = 1'b1;
            state_in  = ST_IX_DIV;
         end
         ST_IX_DIV: begin
            if (div_done) begin
               if (div_q > {20'd0, top_ff}) begin
                  ovf_in = 1'b1;
               end
               if (axis_ff) begin
                  yi_in    = idx;
                  state_in = ST_SEARCH;
               end else begin
                  xi_in    = idx;
                  axis_in  = 1'b1;
                  state_in = ST_IX_MUL1;
               end
            end
         end
         ST_SEARCH: begin
            if (ptr_ff == count_ff) begin
               if (count_ff == CNT_W'(TABLE_DEPTH)) begin
                  ovf_in = 1'b1;
               end else begin
                  ram_we              = 1'b1;
                  ram_waddr           = count_ff[TBL_AW-1:0];
                  wr_ent.tel          = tel_ff;
                  wr_ent.det          = det_ff;
                  wr_ent.xi           = xi_ff;
                  wr_ent.yi           = yi_ff;
                  wr_ent.energy       = {8'd0, e_ff};
                  wr_ent.depth        = z_ff;
                  wr_ent.first_energy = e_ff;
                  count_in            = count_ff + 1'b1;
               end
               state_in = ST_IDLE;
            end else begin
               ram_re   = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (key_hit) begin
               ent_in   = rd_ent;
               state_in = ST_MG_SUM;
            end else begin
               ptr_in   = ptr_ff + 1'b1;
               state_in = ST_SEARCH;
            end
         end
         ST_MG_SUM: begin
            sum_in    = {1'b0, ent_ff.energy} + {9'd0, e_ff};
            prod_a_in = 46'($signed(ent_ff.depth) * $signed({1'b0, ent_ff.energy}));
            state_in  = ST_MG_MUL;
         end
         ST_MG_MUL: begin
            prod_b_in = 38'($signed(z_ff) * $signed({1'b0, e_ff}));
            state_in  = (sum_ff == '0) ? ST_IDLE : ST_MG_NUM;
         end
         ST_MG_NUM: begin
            num_in   = 47'(prod_a_ff) + 47'(prod_b_ff);
            state_in = ST_MG_N2;
         end
         ST_MG_N2: begin
            n2_in    = n2_full[47:0];
            state_in = ST_MG_DST;
         end
         ST_MG_DST: begin
            div_start = 1'b1;
            div_den   = d2;
            neg_in    = n2_ff[47];
            if (n2_ff[47]) begin
               div_num = 48'(-n2_ff) + {14'd0, d2} - 48'd1;
            end else begin
               div_num = n2_ff;
            end
            state_in = ST_MG_DIV;
         end
         ST_MG_DIV: begin
            div_den = d2;
            if (div_done) begin
               ram_we        = 1'b1;
               wr_ent.energy = sum_ff[32] ? 32'hFFFF_FFFF : sum_ff[31:0];
               wr_ent.depth  = neg_ff ? (13'd0 - q_lo) : q_lo;
               state_in      = ST_IDLE;
            end
         end
         ST_FL_READ: begin
            ram_re   = 1'b1;
            state_in = ST_FL_LOAD;
         end
         ST_FL_LOAD: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_kind_in  = KIND_PIXEL;
               out_ovf_in   = ovf_ff;
               out_ent_in   = rd_ent;
               out_last_in  = (ptr_ff + 1'b1 == count_ff);
               if (ptr_ff + 1'b1 == count_ff) begin
                  count_in  = '0;
                  shield_in = 1'b0;
                  ovf_in    = 1'b0;
                  state_in  = ST_IDLE;
               end else begin
                  ptr_in   = ptr_ff + 1'b1;
                  state_in = ST_FL_READ;
               end
            end
         end
         ST_EM_BLK: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_kind_in  = KIND_BLOCKED;
               out_ovf_in   = ovf_ff;
               out_ent_in   = '0;
               out_last_in  = 1'b1;
               shield_in    = 1'b0;
               ovf_in       = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         ST_EM_SHD: begin
            if (out_free) begin
               out_valid_in            = 1'b1;
               out_kind_in             = KIND_SHIELD;
               out_ovf_in              = ovf_ff;
               out_ent_in              = '0;
               out_ent_in.tel          = tel_ff;
               out_ent_in.energy       = {8'd0, e_ff};
               out_ent_in.first_energy = e_ff;
               out_last_in             = 1'b0;
               state_in                = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         half_x_ff    <= 16'd10000;
         half_y_ff    <= 16'd10000;
         pix_x_ff     <= 9'd32;
         pix_y_ff     <= 9'd32;
         count_ff     <= '0;
         ptr_ff       <= '0;
         shield_ff    <= 1'b0;
         ovf_ff       <= 1'b0;
         axis_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         half_x_ff    <= half_x_in;
         half_y_ff    <= half_y_in;
         pix_x_ff     <= pix_x_in;
         pix_y_ff     <= pix_y_in;
         count_ff     <= count_in;
         ptr_ff       <= ptr_in;
         shield_ff    <= shield_in;
         ovf_ff       <= ovf_in;
         axis_ff      <= axis_in;
         out_valid_ff <= out_valid_in;
      end
      tel_ff      <= tel_in;
      det_ff      <= det_in;
      x_ff        <= x_in;
      y_ff        <= y_in;
      z_ff        <= z_in;
      e_ff        <= e_in;
      xi_ff       <= xi_in;
      yi_ff       <= yi_in;
      prod1_ff    <= prod1_in;
      top_ff      <= top_in;
      ent_ff      <= ent_in;
      sum_ff      <= sum_in;
      prod_a_ff   <= prod_a_in;
      prod_b_ff   <= prod_b_in;
      num_ff      <= num_in;
      n2_ff       <= n2_in;
      neg_ff      <= neg_in;
      out_kind_ff <= out_kind_in;
      out_last_ff <= out_last_in;
      out_ovf_ff  <= out_ovf_in;
      out_ent_ff  <= out_ent_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tuser  = {out_ovf_ff, out_kind_ff};
   assign rsp_tdata  = {6'd0, out_ent_ff.first_energy, out_ent_ff.depth,
                        out_ent_ff.energy, out_ent_ff.yi, out_ent_ff.xi,
                        out_ent_ff.det, out_ent_ff.tel};

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(TABLE_DEPTH))
      else $error("hit table count beyond depth");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> (count_ff == $past(count_ff) || count_ff == $past(count_ff) + 1'b1 ||
                count_ff == '0))
      else $error("hit table count jumped");

   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_IX_DIV || state_ff == ST_MG_DIV))
      else $error("divider finished outside a wait state");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_tready && state_ff == ST_FL_LOAD) |=> state_ff == ST_FL_LOAD)
      else $error("flush advanced while result stalled");

endmodule
